### src/rc_throttle_ramp_failsafe_macros.svh
// Assertion macros for the throttle block checker.
`ifndef RC_THROTTLE_RAMP_FAILSAFE_MACROS_SVH
`define RC_THROTTLE_RAMP_FAILSAFE_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define RCTRF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rctrf: same-cycle check failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define RCTRF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rctrf: next-cycle check failed");

`endif

### src/rctrf_pkg.sv
// Shared types, codes and helper functions for the RC throttle block.
package rctrf_pkg;

	// Item opcodes
	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_RISE = 2'd1;
	localparam logic [1:0] OP_FALL = 2'd2;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_RAMP_PERIOD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FAILSAFE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PUNCH       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX   = 3'd5;

	// Reset values
	localparam logic [9:0]  RST_RAMP_PERIOD = 10'd10;
	localparam logic [6:0]  RST_RAMP_STEP   = 7'd2;
	localparam logic [15:0] RST_FAILSAFE    = 16'd200;
	localparam logic [6:0]  RST_PUNCH       = 7'd95;
	localparam logic [11:0] RST_PULSE_MIN   = 12'd800;
	localparam logic [11:0] RST_PULSE_MAX   = 12'd2200;
	localparam logic [11:0] RST_WIDTH       = 12'd1500;

	localparam logic [6:0]  PCT_FULL = 7'd100;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] time_us;
	} item_t;

	typedef struct packed {
		logic [9:0]  ramp_period_ms;
		logic [6:0]  ramp_step_pct;
		logic [15:0] stop_after_ms;
		logic [6:0]  punch_pct;
		logic [11:0] pulse_min_us;
		logic [11:0] pulse_max_us;
	} cfg_t;

	typedef struct packed {
		logic [7:0] duty;
		logic       drive_enable;
		logic       running;
		logic [6:0] current_pct;
		logic [6:0] target_pct;
	} result_t;

	// Pulse width to percent: (w - 1000) / 10, clamped to 0..100.
	// x / 10 for x < 1024 is exact as (x * 205) >> 11.
	function automatic logic [6:0] target_from_width(input logic [11:0] w);
		logic [9:0]  x;
		logic [17:0] prod;
		x    = 10'(w - 12'd1000);
		prod = 18'(x) * 18'd205;
		if (w < 12'd1000)
			return 7'd0;
		else if (w >= 12'd2000)
			return PCT_FULL;
		else
			return prod[17:11];
	endfunction

	// Percent to duty byte: p * 255 / 100, with / 100 as (n * 5243) >> 19.
	function automatic logic [7:0] duty_from_pct(input logic [6:0] p);
		logic [14:0] n;
		logic [27:0] prod;
		n    = {p, 8'd0} - 15'(p);
		prod = 28'(n) * 28'd5243;
		return prod[26:19];
	endfunction

endpackage

### src/rctrf_cfg.sv
// Configuration register file of the RC throttle block.
module rctrf_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [rctrf_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [rctrf_pkg::CFG_DATA_W-1:0] wr_data,
	output rctrf_pkg::cfg_t                 cfg
);

	rctrf_pkg::cfg_t cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ramp_period_ms <= rctrf_pkg::RST_RAMP_PERIOD;
			cfg_q.ramp_step_pct  <= rctrf_pkg::RST_RAMP_STEP;
			cfg_q.stop_after_ms  <= rctrf_pkg::RST_FAILSAFE;
			cfg_q.punch_pct      <= rctrf_pkg::RST_PUNCH;
			cfg_q.pulse_min_us   <= rctrf_pkg::RST_PULSE_MIN;
			cfg_q.pulse_max_us   <= rctrf_pkg::RST_PULSE_MAX;
		end else if (wr_en) begin
			case (wr_index)
				rctrf_pkg::REG_RAMP_PERIOD: cfg_q.ramp_period_ms <= wr_data[9:0];
				rctrf_pkg::REG_RAMP_STEP:   cfg_q.ramp_step_pct  <= wr_data[6:0];
				rctrf_pkg::REG_FAILSAFE:    cfg_q.stop_after_ms  <= wr_data;
				rctrf_pkg::REG_PUNCH:       cfg_q.punch_pct      <= wr_data[6:0];
				rctrf_pkg::REG_PULSE_MIN:   cfg_q.pulse_min_us   <= wr_data[11:0];
				rctrf_pkg::REG_PULSE_MAX:   cfg_q.pulse_max_us   <= wr_data[11:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### src/rctrf_core.sv
// Pulse measurement, failsafe and ramp state with its combinational next-state update.
module rctrf_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  rctrf_pkg::item_t    item,
	input  rctrf_pkg::cfg_t     cfg,
	output rctrf_pkg::result_t  result
);

	logic [31:0] edge_start_q, edge_start_n;
	logic [11:0] pending_q, pending_n;
	logic        fresh_q, fresh_n;
	logic [11:0] held_q, held_n;
	logic [15:0] ms_pulse_q, ms_pulse_n;
	logic [9:0]  ms_step_q, ms_step_n;
	logic [6:0]  drive_q, drive_n;
	logic        enable_q, enable_n;
	logic        run_q, run_n;

	logic [31:0] width;
	logic [6:0]  target;
	logic [7:0]  up_sum;
	logic [6:0]  down_val;

	// Next-state logic for one transaction
	always_comb begin
		edge_start_n = edge_start_q;
		pending_n    = pending_q;
		fresh_n      = fresh_q;
		held_n       = held_q;
		ms_pulse_n   = ms_pulse_q;
		ms_step_n    = ms_step_q;
		drive_n      = drive_q;
		enable_n     = enable_q;
		run_n        = run_q;

		width  = item.time_us - edge_start_q;
		target = 7'd0;
		up_sum = 8'd0;
		down_val = 7'd0;

		case (item.opcode)
			rctrf_pkg::OP_RISE: begin
				edge_start_n = item.time_us;
			end
			rctrf_pkg::OP_FALL: begin
				if (width >= {20'd0, cfg.pulse_min_us} && width <= {20'd0, cfg.pulse_max_us}) begin
					pending_n = width[11:0];
					fresh_n   = 1'b1;
				end
			end
			rctrf_pkg::OP_TICK: begin
				// saturating counters
				if (ms_pulse_q != '1)
					ms_pulse_n = ms_pulse_q + 16'd1;
				if (ms_step_q != '1)
					ms_step_n = ms_step_q + 10'd1;
				// take up a fresh pulse
				if (fresh_q) begin
					held_n     = pending_q;
					fresh_n    = 1'b0;
					ms_pulse_n = 16'd0;
				end
				target = rctrf_pkg::target_from_width(held_n);
				up_sum = {1'b0, drive_q} + {1'b0, cfg.ramp_step_pct};
				down_val = (drive_q > cfg.ramp_step_pct) ? (drive_q - cfg.ramp_step_pct) : 7'd0;
				if (ms_pulse_n > cfg.stop_after_ms) begin
					// failsafe: forced stop
					drive_n  = 7'd0;
					enable_n = 1'b0;
					run_n    = 1'b0;
				end else if (ms_step_n >= cfg.ramp_period_ms) begin
					ms_step_n = 10'd0;
					if (target >= cfg.punch_pct) begin
						drive_n  = rctrf_pkg::PCT_FULL;
						enable_n = 1'b1;
						run_n    = 1'b1;
					end else if (drive_q < target) begin
						drive_n  = (up_sum > {1'b0, target}) ? target : up_sum[6:0];
						enable_n = 1'b1;
						run_n    = 1'b1;
					end else if (drive_q > target) begin
						drive_n = (down_val < target) ? target : down_val;
						if (drive_n == 7'd0) begin
							enable_n = 1'b0;
							run_n    = 1'b0;
						end
					end
				end
			end
			default: ;
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_start_q <= '0;
			pending_q    <= rctrf_pkg::RST_WIDTH;
			fresh_q      <= 1'b0;
			held_q       <= rctrf_pkg::RST_WIDTH;
			ms_pulse_q   <= '0;
			ms_step_q    <= '0;
			drive_q      <= '0;
			enable_q     <= 1'b1;
			run_q        <= 1'b0;
		end else if (fire) begin
			edge_start_q <= edge_start_n;
			pending_q    <= pending_n;
			fresh_q      <= fresh_n;
			held_q       <= held_n;
			ms_pulse_q   <= ms_pulse_n;
			ms_step_q    <= ms_step_n;
			drive_q      <= drive_n;
			enable_q     <= enable_n;
			run_q        <= run_n;
		end
	end

	// Result shows the state after this transaction
	always_comb begin
		result.duty         = rctrf_pkg::duty_from_pct(drive_n);
		result.drive_enable = enable_n;
		result.running      = run_n;
		result.current_pct  = drive_n;
		result.target_pct   = rctrf_pkg::target_from_width(held_n);
	end

endmodule

### src/rc_throttle_ramp_failsafe.sv
// Top level of the RC throttle block: input stage, state update, result register.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    opcode, time_us
//   out      source     out_valid / out_stall  duty, drive_enable, running,
//                                              current_pct, target_pct
//   cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One transaction per cycle while out_stall is low; each accepted transaction
// passes the input register, then the state update into the result register.
// The state update for one item is compare/add logic, so items may follow back
// to back. arst_n clears the valid flags, the config registers and the core
// state to their reset values; the item and result data registers have no reset.
// A stalled result holds the result register; the input register still takes one
// more item, after which in_stall rises until the result is taken. cfg_ready is
// always high; users change registers only while the block is idle (unenforced).
module rc_throttle_ramp_failsafe (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      opcode,
	input  logic [31:0]                     time_us,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      duty,
	output logic                            drive_enable,
	output logic                            running,
	output logic [6:0]                      current_pct,
	output logic [6:0]                      target_pct,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rctrf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rctrf_pkg::CFG_DATA_W-1:0] cfg_data
);

	rctrf_pkg::cfg_t    cfg;
	rctrf_pkg::item_t   item_s1;
	rctrf_pkg::result_t result;
	rctrf_pkg::result_t out_s2;
	logic               valid_s1;
	logic               out_valid_q;
	logic               advance;

	assign cfg_ready = 1'b1;

	rctrf_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Stage 1 moves on when the result register is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.opcode  <= opcode;
			item_s1.time_us <= time_us;
		end
	end

	rctrf_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_s2 <= result;
	end

	assign out_valid    = out_valid_q;
	assign duty         = out_s2.duty;
	assign drive_enable = out_s2.drive_enable;
	assign running      = out_s2.running;
	assign current_pct  = out_s2.current_pct;
	assign target_pct   = out_s2.target_pct;

endmodule

### src/rctrf_checker.sv
// Port-level checker for the RC throttle block, bound to the top level.
`include "rc_throttle_ramp_failsafe_macros.svh"

module rctrf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] duty,
	input logic       drive_enable,
	input logic       running,
	input logic [6:0] current_pct,
	input logic [6:0] target_pct
);

	// A stalled result stays put
	`RCTRF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(duty) && $stable(current_pct))

	// Percent fields stay in range
	`RCTRF_ASSERT_NOW(a_pct_range, out_valid, current_pct <= 7'd100 && target_pct <= 7'd100)

	// Full drive maps to full duty
	`RCTRF_ASSERT_NOW(a_full_duty, out_valid && current_pct == 7'd100, duty == 8'd255)

	// Running is only reported with the controller enabled
	`RCTRF_ASSERT_NOW(a_run_enable, out_valid && running, drive_enable)

endmodule

bind rc_throttle_ramp_failsafe rctrf_checker u_rctrf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.duty         (duty),
	.drive_enable (drive_enable),
	.running      (running),
	.current_pct  (current_pct),
	.target_pct   (target_pct)
);

### sim/tb_rc_throttle_ramp_failsafe.sv
// Self-checking testbench for rc_throttle_ramp_failsafe: pulse capture, ramp, punch and failsafe.
module tb_rc_throttle_ramp_failsafe;

	// Opcode with no meaning; the block passes it through as a no-op
	localparam logic [1:0] OP_SPARE = 2'd3;
	// Register indexes with no register behind them
	localparam logic [rctrf_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [rctrf_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam int PULSE_CNT_TOP = 65535;
	localparam int STEP_CNT_TOP  = 1023;
	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES   = 60;
	localparam int ITEMS_PER_SET = 48;

	// Idle profiles: none, sender only, receiver only, both
	localparam int GAP_PCT   [4] = '{0, 48, 0, 29};
	localparam int STALL_PCT [4] = '{0, 0, 48, 29};

	// Register settings: period, step, failsafe, punch, pulse min, pulse max
	localparam int KNOB_SETS [8][6] = '{
		'{10,   2,   200,   95,  800,  2200},
		'{1,    127, 1,     0,   0,    4095},
		'{0,    0,   20,    127, 800,  2200},
		'{2,    5,   15,    101, 1000, 2000},
		'{3,    7,   25,    60,  900,  2100},
		'{1023, 1,   65535, 101, 4095, 0},
		'{1,    3,   10,    100, 950,  2050},
		'{1,    100, 8,     96,  1200, 1800}
	};

	typedef struct packed {
		logic [1:0]          op;
		logic [31:0]         stamp;
		logic                pinned;
		rctrf_pkg::result_t  want;
	} script_row_t;

	// Results that can be read straight off the reset state
	localparam rctrf_pkg::result_t R_RST  = {8'd0, 1'b1, 1'b0, 7'd0, 7'd50};
	localparam rctrf_pkg::result_t R_T100 = {8'd0, 1'b1, 1'b0, 7'd0, 7'd100};
	localparam rctrf_pkg::result_t R_FULL = {8'd255, 1'b1, 1'b1, 7'd100, 7'd100};
	localparam rctrf_pkg::result_t R_NONE = '0;

	// Directed opening under reset settings
	localparam script_row_t SCRIPT [25] = '{
		{rctrf_pkg::OP_TICK, 32'h0000_0000, 1'b1, R_RST},
		{OP_SPARE,           32'hFFFF_FFFF, 1'b1, R_RST},
		{rctrf_pkg::OP_RISE, 32'hFFFF_FFFF, 1'b1, R_RST},
		{rctrf_pkg::OP_FALL, 32'h0000_07CF, 1'b1, R_RST},  // wraps: width 2000
		{rctrf_pkg::OP_TICK, 32'h1234_5678, 1'b1, R_T100},
		{rctrf_pkg::OP_TICK, 32'hAAAA_5555, 1'b0, R_NONE},
		{rctrf_pkg::OP_TICK, 32'h5555_AAAA, 1'b0, R_NONE},
		{rctrf_pkg::OP_TICK, 32'hFFFF_0000, 1'b0, R_NONE},
		{rctrf_pkg::OP_TICK, 32'h0000_FFFF, 1'b0, R_NONE},
		{rctrf_pkg::OP_TICK, 32'h8000_0001, 1'b0, R_NONE},
		{rctrf_pkg::OP_TICK, 32'h7FFF_FFFE, 1'b0, R_NONE},
		{rctrf_pkg::OP_TICK, 32'hDEAD_0000, 1'b0, R_NONE},
		{rctrf_pkg::OP_TICK, 32'h0000_0001, 1'b1, R_FULL},  // ramp period reached, punch
		{rctrf_pkg::OP_RISE, 32'h0000_0000, 1'b0, R_NONE},
		{rctrf_pkg::OP_FALL, 32'h0000_0320, 1'b0, R_NONE},  // exactly the minimum
		{rctrf_pkg::OP_TICK, 32'hFFFF_FFFF, 1'b0, R_NONE},
		{rctrf_pkg::OP_RISE, 32'h0000_03E8, 1'b0, R_NONE},
		{rctrf_pkg::OP_FALL, 32'h0000_0C81, 1'b0, R_NONE},  // one over the maximum
		{rctrf_pkg::OP_RISE, 32'h0000_0005, 1'b0, R_NONE},
		{rctrf_pkg::OP_FALL, 32'h0000_0324, 1'b0, R_NONE},  // one under the minimum
		{rctrf_pkg::OP_RISE, 32'h8000_0000, 1'b0, R_NONE},
		{rctrf_pkg::OP_FALL, 32'h8000_0898, 1'b0, R_NONE},  // exactly the maximum
		{rctrf_pkg::OP_TICK, 32'h0F0F_0F0F, 1'b0, R_NONE},
		{rctrf_pkg::OP_FALL, 32'h8000_05DC, 1'b0, R_NONE},  // second fall on the same rise
		{rctrf_pkg::OP_TICK, 32'hF0F0_F0F0, 1'b0, R_NONE}
	};

	logic                             clk          = 1'b0;
	logic                             arst_n       = 1'b0;
	logic                             in_valid     = 1'b0;
	logic                             in_stall;
	logic [1:0]                       opcode       = rctrf_pkg::OP_TICK;
	logic [31:0]                      time_us      = '0;
	logic                             out_valid;
	logic                             out_stall    = 1'b0;
	logic [7:0]                       duty;
	logic                             drive_enable;
	logic                             running;
	logic [6:0]                       current_pct;
	logic [6:0]                       target_pct;
	logic                             cfg_valid    = 1'b0;
	logic                             cfg_ready;
	logic [rctrf_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [rctrf_pkg::CFG_DATA_W-1:0] cfg_data     = '0;

	// Throttle state as the block should hold it
	rctrf_pkg::cfg_t knobs;
	logic [31:0]     rise_stamp;
	logic [11:0]     waiting_width;
	bit              width_waiting;
	logic [11:0]     held_width;
	int              ms_no_pulse;
	int              ms_no_step;
	int              level_pct;
	bit              drive_en_q;
	bit              run_q;

	rctrf_pkg::result_t drive_status_q [$];

	int in_gap_pct    = 0;
	int out_stall_pct = 0;
	bit hold_req      = 1'b0;
	int hold_left     = 0;
	int quiet_cycles  = 0;
	int useful_items  = 0;
	int accepted      = 0;
	int checked       = 0;
	int err_count     = 0;
	int settings_used = 0;

	rc_throttle_ramp_failsafe uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.time_us      (time_us),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.duty         (duty),
		.drive_enable (drive_enable),
		.running      (running),
		.current_pct  (current_pct),
		.target_pct   (target_pct),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Pulse width in us to throttle percent, truncated and clamped
	function automatic logic [6:0] pct_from_width(input logic [11:0] w);
		int t;
		if (w < 12'd1000)
			return 7'd0;
		t = (int'(w) - 1000) / 10;
		return (t > 100) ? 7'd100 : 7'(t);
	endfunction

	// Apply one transaction to the throttle state and return the status it shows
	function automatic rctrf_pkg::result_t advance_throttle(input logic [1:0] op,
			input logic [31:0] stamp);
		logic [31:0]        span;
		int                 goal;
		int                 lvl;
		rctrf_pkg::result_t r;
		case (op)
			rctrf_pkg::OP_TICK: begin
				if (ms_no_pulse < PULSE_CNT_TOP)
					ms_no_pulse++;
				if (ms_no_step < STEP_CNT_TOP)
					ms_no_step++;
				if (width_waiting) begin
					held_width    = waiting_width;
					width_waiting = 1'b0;
					ms_no_pulse   = 0;
				end
				if (ms_no_pulse > int'(knobs.stop_after_ms)) begin
					level_pct  = 0;
					drive_en_q = 1'b0;
					run_q      = 1'b0;
				end else if (ms_no_step >= int'(knobs.ramp_period_ms)) begin
					ms_no_step = 0;
					goal = int'(pct_from_width(held_width));
					if (goal >= int'(knobs.punch_pct)) begin
						level_pct  = 100;
						drive_en_q = 1'b1;
						run_q      = 1'b1;
					end else if (level_pct < goal) begin
						lvl        = level_pct + int'(knobs.ramp_step_pct);
						level_pct  = (lvl > goal) ? goal : lvl;
						drive_en_q = 1'b1;
						run_q      = 1'b1;
					end else if (level_pct > goal) begin
						lvl = (level_pct > int'(knobs.ramp_step_pct)) ?
							level_pct - int'(knobs.ramp_step_pct) : 0;
						if (lvl < goal)
							lvl = goal;
						level_pct = lvl;
						if (lvl == 0) begin
							drive_en_q = 1'b0;
							run_q      = 1'b0;
						end
					end
				end
			end
			rctrf_pkg::OP_RISE: rise_stamp = stamp;
			rctrf_pkg::OP_FALL: begin
				span = stamp - rise_stamp;
				if (span >= 32'(knobs.pulse_min_us) && span <= 32'(knobs.pulse_max_us)) begin
					waiting_width = span[11:0];
					width_waiting = 1'b1;
				end
			end
			default: ;
		endcase
		r.duty         = 8'(level_pct * 255 / 100);
		r.drive_enable = drive_en_q;
		r.running      = run_q;
		r.current_pct  = 7'(level_pct);
		r.target_pct   = pct_from_width(held_width);
		return r;
	endfunction

	function automatic void set_knob(input logic [rctrf_pkg::CFG_IDX_W-1:0] idx,
			input logic [rctrf_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			rctrf_pkg::REG_RAMP_PERIOD: knobs.ramp_period_ms = data[9:0];
			rctrf_pkg::REG_RAMP_STEP:   knobs.ramp_step_pct  = data[6:0];
			rctrf_pkg::REG_FAILSAFE:    knobs.stop_after_ms  = data[15:0];
			rctrf_pkg::REG_PUNCH:       knobs.punch_pct      = data[6:0];
			rctrf_pkg::REG_PULSE_MIN:   knobs.pulse_min_us   = data[11:0];
			rctrf_pkg::REG_PULSE_MAX:   knobs.pulse_max_us   = data[11:0];
			default: ;
		endcase
	endfunction

	// Random bits above a register's width, which the block must drop
	function automatic logic [15:0] junk_above(input int w);
		return $urandom_range(1) ? (16'($urandom) << w) : 16'd0;
	endfunction

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		if (err_count < 40)
			$display("MISMATCH %s: got %0d, want %0d (result %0d)", what, got, want, checked);
		err_count++;
	endtask

	// Offer one transaction, with random sender gaps, and record its outcome on acceptance
	task automatic offer(input logic [1:0] op, input logic [31:0] stamp,
			input bit pinned, input rctrf_pkg::result_t want);
		rctrf_pkg::result_t r;
		while ($urandom_range(99) < in_gap_pct) begin
			in_valid <= 1'b0;
			opcode   <= 2'($urandom);
			time_us  <= $urandom;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		time_us  <= stamp;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		r = advance_throttle(op, stamp);
		drive_status_q.push_back(pinned ? want : r);
		accepted++;
		if (op != OP_SPARE)
			useful_items++;
	endtask

	task automatic send(input logic [1:0] op, input logic [31:0] stamp);
		offer(op, stamp, 1'b0, R_NONE);
	endtask

	task automatic write_knob(input logic [rctrf_pkg::CFG_IDX_W-1:0] idx,
			input logic [rctrf_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		set_knob(idx, data);
	endtask

	// Drain the block, then write every register plus one unmapped index
	task automatic load_knobs(input int period, input int step, input int failsafe,
			input int punch, input int lo, input int hi);
		in_valid <= 1'b0;
		while (drive_status_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_knob(rctrf_pkg::REG_RAMP_PERIOD, junk_above(10) | 16'(period));
		write_knob(rctrf_pkg::REG_RAMP_STEP, junk_above(7) | 16'(step));
		write_knob(rctrf_pkg::REG_FAILSAFE, 16'(failsafe));
		write_knob(rctrf_pkg::REG_PUNCH, junk_above(7) | 16'(punch));
		write_knob(rctrf_pkg::REG_PULSE_MIN, junk_above(12) | 16'(lo));
		write_knob(rctrf_pkg::REG_PULSE_MAX, junk_above(12) | 16'(hi));
		write_knob($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, 16'($urandom));
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Mostly whole pulses followed by ticks, with tick bursts, noise and broken edges mixed in
	task automatic run_traffic(input int budget);
		int          goal;
		int          pick;
		logic [31:0] t0;
		logic [31:0] w;
		goal = useful_items + budget;
		while (useful_items < goal) begin
			pick = $urandom_range(99);
			if (pick < 65) begin
				case ($urandom_range(9))
					0: w = 32'(knobs.pulse_min_us);
					1: w = 32'(knobs.pulse_max_us);
					2: w = 32'(knobs.pulse_min_us) - 32'd1;
					3: w = 32'(knobs.pulse_max_us) + 32'd1;
					4: w = $urandom_range(4095);
					5: w = $urandom;
					default: w = $urandom_range(2050, 1000);
				endcase
				t0 = $urandom;
				send(rctrf_pkg::OP_RISE, t0);
				send(rctrf_pkg::OP_FALL, t0 + w);
				repeat ($urandom_range(10, 1)) send(rctrf_pkg::OP_TICK, $urandom);
			end else if (pick < 78) begin
				repeat ($urandom_range(40, 5)) send(rctrf_pkg::OP_TICK, $urandom);
			end else if (pick < 90) begin
				send(2'($urandom_range(3)), $urandom);
			end else if (pick < 95) begin
				send(rctrf_pkg::OP_FALL, $urandom);
			end else begin
				send(rctrf_pkg::OP_RISE, $urandom);
				send(rctrf_pkg::OP_RISE, $urandom);
				send(rctrf_pkg::OP_FALL, $urandom);
			end
		end
	endtask

	// Receiver stalls: random, or one long counted hold-off on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < out_stall_pct);
		end
	end

	// Result checker
	always @(posedge clk) begin
		rctrf_pkg::result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (drive_status_q.size() == 0) begin
				flag_mismatch("result with nothing outstanding", duty, 0);
			end else begin
				want = drive_status_q.pop_front();
				if (duty != want.duty)
					flag_mismatch("duty", duty, want.duty);
				if (drive_enable != want.drive_enable)
					flag_mismatch("drive_enable", drive_enable, want.drive_enable);
				if (running != want.running)
					flag_mismatch("running", running, want.running);
				if (current_pct != want.current_pct)
					flag_mismatch("current_pct", current_pct, want.current_pct);
				if (target_pct != want.target_pct)
					flag_mismatch("target_pct", target_pct, want.target_pct);
			end
			checked++;
		end
	end

	// Watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
				$display("tb_rc_throttle_ramp_failsafe: errors");
				$finish;
			end
		end
	end

	initial begin
		int s;
		int waited;
		knobs = {rctrf_pkg::RST_RAMP_PERIOD, rctrf_pkg::RST_RAMP_STEP,
			rctrf_pkg::RST_FAILSAFE, rctrf_pkg::RST_PUNCH,
			rctrf_pkg::RST_PULSE_MIN, rctrf_pkg::RST_PULSE_MAX};
		rise_stamp    = '0;
		waiting_width = rctrf_pkg::RST_WIDTH;
		width_waiting = 1'b0;
		held_width    = rctrf_pkg::RST_WIDTH;
		ms_no_pulse   = 0;
		ms_no_step    = 0;
		level_pct     = 0;
		drive_en_q    = 1'b1;
		run_q         = 1'b0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening, no idling
		for (s = 0; s < 25; s++)
			offer(SCRIPT[s].op, SCRIPT[s].stamp, SCRIPT[s].pinned, SCRIPT[s].want);

		// Random traffic over each register setting, cycling the idle profiles
		for (s = 0; s < 8; s++) begin
			load_knobs(KNOB_SETS[s][0], KNOB_SETS[s][1], KNOB_SETS[s][2],
				KNOB_SETS[s][3], KNOB_SETS[s][4], KNOB_SETS[s][5]);
			in_gap_pct    = GAP_PCT[s % 4];
			out_stall_pct = STALL_PCT[s % 4];
			if (s == 2 || s == 7)
				hold_req = 1'b1;
			run_traffic(ITEMS_PER_SET);
		end
		in_valid <= 1'b0;

		waited = 0;
		while (drive_status_q.size() != 0 && waited < QUIET_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (drive_status_q.size() != 0)
			flag_mismatch("results never delivered", drive_status_q.size(), 0);

		$display("covered %0d transactions (%0d edges and ticks) across %0d register settings,",
			accepted, useful_items, settings_used);
		$display("with idle mixes and long receiver hold-offs; %0d results checked, %0d mismatches",
			checked, err_count);
		if (err_count == 0)
			$display("tb_rc_throttle_ramp_failsafe: clean");
		else
			$display("tb_rc_throttle_ramp_failsafe: errors");
		$finish;
	end

endmodule
